/* rtl/phfa_pkg.sv */
// Shared types, constants and helpers of the per-hart page free list allocator.
`timescale 1ns / 1ps
`default_nettype none

package phfa_pkg;

    // Geometry
    localparam int HART_COUNT  = 8;
    localparam int PAGE_BYTES  = 4096;
    localparam int MAX_PAGES   = 32768;

    localparam int ADDR_W      = 32;
    localparam int HART_IN_W   = 3;
    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int PN_W        = ADDR_W - PAGE_SHIFT;
    localparam int HART_W      = (HART_COUNT > 1) ? $clog2(HART_COUNT) : 1;
    localparam int SLOT_W      = $clog2(MAX_PAGES);
    localparam int LINK_W      = SLOT_W + 1;
    localparam logic [LINK_W-1:0] NO_SLOT = LINK_W'(MAX_PAGES);

    // Stream widths
    localparam int S_TDATA_W   = 40;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 32;
    localparam int M_TUSER_W   = 2;

    // Configuration port
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POOL_STOP  = 1'd1;
    localparam logic [ADDR_W-1:0] POOL_START_RST = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] POOL_STOP_RST  = 32'h8800_0000;

    // Command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Request operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMEM   = 2'd1,
        ST_BADFREE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_BAD   = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [HART_W-1:0]   hart;
        logic [SLOT_W-1:0]   slot;
    } cmd_t;

    // Page number of pool_start rounded up to a whole page
    function automatic logic [PN_W:0] base_pn(input logic [ADDR_W-1:0] start);
        logic [PN_W:0] pn;
        pn = {1'b0, start[ADDR_W-1:PAGE_SHIFT]}
           + (PN_W+1)'(|start[PAGE_SHIFT-1:0]);
        return pn;
    endfunction

endpackage

`default_nettype wire

/* rtl/phfa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module phfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

/* rtl/phfa_front.sv */
// Front end: accept requests, check free addresses and turn them into commands.
`timescale 1ns / 1ps
`default_nettype none

module phfa_front (
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [phfa_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic [phfa_pkg::S_TUSER_W-1:0]    s_tuser,
    input  wire logic [phfa_pkg::ADDR_W-1:0]       pool_start,
    input  wire logic [phfa_pkg::ADDR_W-1:0]       pool_stop,
    input  wire logic                              q_full,
    output logic                                   q_push,
    output phfa_pkg::cmd_t                         q_cmd
);

    logic                              op;
    logic [phfa_pkg::HART_IN_W-1:0]    hart_in;
    logic [phfa_pkg::ADDR_W-1:0]       addr;
    logic [phfa_pkg::PN_W:0]           pool_pn;
    logic [phfa_pkg::PN_W:0]           slot_diff;
    logic                              aligned;
    logic                              in_range;
    logic                              slot_fits;

    // Unpack the request
    assign op      = s_tuser[0];
    assign hart_in = s_tdata[phfa_pkg::HART_IN_W-1:0];
    assign addr    = s_tdata[phfa_pkg::HART_IN_W +: phfa_pkg::ADDR_W];

    // Classify a free: alignment, pool bounds, slot within the link store
    assign pool_pn   = phfa_pkg::base_pn(pool_start);
    assign slot_diff = {1'b0, addr[phfa_pkg::ADDR_W-1:phfa_pkg::PAGE_SHIFT]} - pool_pn;
    assign aligned   = (addr[phfa_pkg::PAGE_SHIFT-1:0] == '0);
    assign in_range  = (addr >= pool_start) && (addr < pool_stop);
    assign slot_fits = (32'(slot_diff) < 32'(phfa_pkg::MAX_PAGES));

    // Build the command
    always_comb begin
        q_cmd.hart = phfa_pkg::HART_W'(hart_in);
        q_cmd.slot = phfa_pkg::SLOT_W'(slot_diff);
        if (op == phfa_pkg::OP_ALLOC) begin
            q_cmd.kind = phfa_pkg::CMD_ALLOC;
        end else if (aligned && in_range && slot_fits) begin
            q_cmd.kind = phfa_pkg::CMD_FREE;
        end else begin
            q_cmd.kind = phfa_pkg::CMD_BAD;
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

endmodule

`default_nettype wire

/* rtl/phfa_queue.sv */
// Short command queue between the front end and the list engine.
`timescale 1ns / 1ps
`default_nettype none

module phfa_queue (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        push,
    input  wire phfa_pkg::cmd_t              push_cmd,
    output logic                             full,
    output logic                             valid,
    input  wire logic                        pop,
    output phfa_pkg::cmd_t                   head_cmd,
    output logic [phfa_pkg::QCNT_W-1:0]      count
);

    phfa_pkg::cmd_t                  entry_reg [phfa_pkg::QUEUE_DEPTH];
    logic [phfa_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [phfa_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [phfa_pkg::QCNT_W-1:0]     count_reg;
    logic                            do_push;
    logic                            do_pop;

    assign full     = (count_reg == phfa_pkg::QCNT_W'(phfa_pkg::QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign head_cmd = entry_reg[rd_ptr_reg];
    assign count    = count_reg;
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    // Store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/phfa_back.sv */
// List engine: per-hart list heads, shared link memory and the result register.
`timescale 1ns / 1ps
`default_nettype none

module phfa_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cmd_valid,
    input  wire phfa_pkg::cmd_t                cmd,
    output logic                               cmd_pop,
    input  wire logic [phfa_pkg::ADDR_W-1:0]   pool_start,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output logic [phfa_pkg::ADDR_W-1:0]        res_addr,
    output phfa_pkg::status_t                  res_status
);

    typedef enum logic {
        S_IDLE,
        S_POP
    } state_t;

    state_t                              state_reg;
    logic [phfa_pkg::LINK_W-1:0]         head_reg [phfa_pkg::HART_COUNT];
    logic [phfa_pkg::HART_W-1:0]         sel_reg;
    logic [phfa_pkg::SLOT_W-1:0]         slot_reg;
    logic                                res_valid_reg;
    logic [phfa_pkg::ADDR_W-1:0]         res_addr_reg;
    phfa_pkg::status_t                   res_status_reg;

    logic                                out_free;
    logic                                res_load;
    logic [phfa_pkg::HART_COUNT-1:0]     nonempty_rot;
    logic                                found;
    logic [phfa_pkg::HART_W-1:0]         sel;
    logic [phfa_pkg::LINK_W-1:0]         sel_head;
    logic                                ram_we;
    logic [phfa_pkg::LINK_W-1:0]         ram_rdata;
    logic [phfa_pkg::PN_W:0]             pool_pn;
    logic [phfa_pkg::ADDR_W-1:0]         page_num;

    assign out_free = !res_valid_reg || res_ready;
    assign cmd_pop  = (state_reg == S_IDLE) && cmd_valid && out_free;

    // A response is loaded this cycle in S_POP, or on a pop unless a found allocate goes on to its link read
    assign res_load = (state_reg == S_POP)
                   || (cmd_pop && !((cmd.kind == phfa_pkg::CMD_ALLOC) && found));

    // Scan lists starting at the requesting hart, wrapping upward
    always_comb begin
        found = 1'b0;
        sel   = cmd.hart;
        for (int i = 0; i < phfa_pkg::HART_COUNT; i++) begin
            nonempty_rot[i] =
                (head_reg[phfa_pkg::HART_W'(cmd.hart + phfa_pkg::HART_W'(i))] != phfa_pkg::NO_SLOT);
        end
        for (int i = phfa_pkg::HART_COUNT - 1; i >= 0; i--) begin
            if (nonempty_rot[i]) begin
                found = 1'b1;
                sel   = phfa_pkg::HART_W'(cmd.hart + phfa_pkg::HART_W'(i));
            end
        end
    end

    assign sel_head = head_reg[sel];
    assign ram_we   = cmd_pop && (cmd.kind == phfa_pkg::CMD_FREE);

    // Link memory: a free writes the old head, a pop reads the next link
    phfa_ram #(
        .WIDTH (phfa_pkg::LINK_W),
        .DEPTH (phfa_pkg::MAX_PAGES)
    ) u_links (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cmd.slot),
        .wdata (head_reg[cmd.hart]),
        .raddr (sel_head[phfa_pkg::SLOT_W-1:0]),
        .rdata (ram_rdata)
    );

    // Address of the popped slot from the current pool base
    assign pool_pn  = phfa_pkg::base_pn(pool_start);
    assign page_num = 32'(pool_pn) + 32'(slot_reg);

    // Sequencer, list heads and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < phfa_pkg::HART_COUNT; i++) begin
                head_reg[i] <= phfa_pkg::NO_SLOT;
            end
        end else begin
            if (res_valid_reg && res_ready && !res_load) begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (cmd_pop) begin
                        case (cmd.kind)
                            phfa_pkg::CMD_FREE: begin
                                head_reg[cmd.hart] <= phfa_pkg::LINK_W'(cmd.slot);
                                res_valid_reg      <= 1'b1;
                                res_addr_reg       <= '0;
                                res_status_reg     <= phfa_pkg::ST_OK;
                            end
                            phfa_pkg::CMD_ALLOC: begin
                                if (found) begin
                                    sel_reg   <= sel;
                                    slot_reg  <= sel_head[phfa_pkg::SLOT_W-1:0];
                                    state_reg <= S_POP;
                                end else begin
                                    res_valid_reg  <= 1'b1;
                                    res_addr_reg   <= '0;
                                    res_status_reg <= phfa_pkg::ST_NOMEM;
                                end
                            end
                            default: begin
                                res_valid_reg  <= 1'b1;
                                res_addr_reg   <= '0;
                                res_status_reg <= phfa_pkg::ST_BADFREE;
                            end
                        endcase
                    end
                end
                S_POP: begin
                    // Link read has landed: unlink the head and hand out its page
                    head_reg[sel_reg] <= ram_rdata;
                    res_valid_reg     <= 1'b1;
                    res_addr_reg      <= page_num << phfa_pkg::PAGE_SHIFT;
                    res_status_reg    <= phfa_pkg::ST_OK;
                    state_reg         <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res_valid  = res_valid_reg;
    assign res_addr   = res_addr_reg;
    assign res_status = res_status_reg;

endmodule

`default_nettype wire

/* rtl/per_hart_page_free_list_allocator.sv */
// Top level of the per-hart page free list allocator.
// A free (good or bad) passes the command queue and the result register; an allocate also
// passes S_POP, the registered read of the shared link memory; a failed allocate skips it.
// Throughput: one free per cycle while responses are taken; an allocate holds the engine in
// S_POP and no command is taken then; a 2-entry command queue decouples the request side.
// Reset (aresetn low, synchronous): all lists empty, pool bounds to their defaults;
// the link memory is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module per_hart_page_free_list_allocator (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // request: tdata = hart[2:0], page_addr[34:3], zero pad[39:35]
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [phfa_pkg::S_TDATA_W-1:0]      s_tdata,
    // request: tuser = operation[0]
    input  wire logic [phfa_pkg::S_TUSER_W-1:0]      s_tuser,
    // response: tdata = result_addr[31:0]
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [phfa_pkg::M_TDATA_W-1:0]           m_tdata,
    // response: tuser = status[1:0]
    output logic [phfa_pkg::M_TUSER_W-1:0]           m_tuser,
    input  wire logic                                cfg_wr_en,
    input  wire logic [phfa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [phfa_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    logic [phfa_pkg::ADDR_W-1:0]   pool_start_reg;
    logic [phfa_pkg::ADDR_W-1:0]   pool_stop_reg;
    logic                          q_full;
    logic                          q_push;
    phfa_pkg::cmd_t                q_in_cmd;
    logic                          q_valid;
    logic                          q_pop;
    phfa_pkg::cmd_t                q_head_cmd;
    logic [phfa_pkg::QCNT_W-1:0]   q_count;
    logic [phfa_pkg::ADDR_W-1:0]   res_addr;
    phfa_pkg::status_t             res_status;

    // Pool bound registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_start_reg <= phfa_pkg::POOL_START_RST;
            pool_stop_reg  <= phfa_pkg::POOL_STOP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                phfa_pkg::REG_POOL_START: pool_start_reg <= cfg_wr_data;
                phfa_pkg::REG_POOL_STOP:  pool_stop_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    phfa_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .pool_start (pool_start_reg),
        .pool_stop  (pool_stop_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_in_cmd)
    );

    phfa_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_in_cmd),
        .full     (q_full),
        .valid    (q_valid),
        .pop      (q_pop),
        .head_cmd (q_head_cmd),
        .count    (q_count)
    );

    phfa_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (q_valid),
        .cmd        (q_head_cmd),
        .cmd_pop    (q_pop),
        .pool_start (pool_start_reg),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_addr   (res_addr),
        .res_status (res_status)
    );

    assign m_tdata = res_addr;
    assign m_tuser = res_status;

    // A failed request never carries an address
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != phfa_pkg::ST_OK) |-> (m_tdata == '0))
        else $error("nonzero address on failed request");

    // Queue never holds more than its depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= phfa_pkg::QCNT_W'(phfa_pkg::QUEUE_DEPTH))
        else $error("command queue overfilled");

    // Queue refuses requests exactly when full
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (q_count != phfa_pkg::QCNT_W'(phfa_pkg::QUEUE_DEPTH)))
        else $error("request ready disagrees with queue fill");

    // No response right after a reset edge
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("response valid after reset");

endmodule

`default_nettype wire
